// File: design/dsrdd_pkg.sv
package dsrdd_pkg;

   localparam int RATE_W  = 16;
   localparam int COUNT_W = 24;
   localparam int PULSE_W = 8;
   localparam int TPS_W   = 24;
   localparam int LOW_W   = 24;
   localparam int NUM_W   = 2 * RATE_W;
   localparam int DVD_W   = TPS_W + RATE_W;

   localparam int STEP_COUNT_BITS_DEF = 24;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] REG_START_RATE = 3'd0;
   localparam logic [2:0] REG_MAX_RATE   = 3'd1;
   localparam logic [2:0] REG_RAMP_STEPS = 3'd2;
   localparam logic [2:0] REG_TOTAL      = 3'd3;
   localparam logic [2:0] REG_PULSE      = 3'd4;
   localparam logic [2:0] REG_TPS        = 3'd5;

   localparam logic [RATE_W-1:0]  START_RATE_RST = 16'd200;
   localparam logic [RATE_W-1:0]  MAX_RATE_RST   = 16'd2000;
   localparam logic [RATE_W-1:0]  RAMP_RST       = 16'd200;
   localparam logic [COUNT_W-1:0] TOTAL_RST      = 24'd10000;
   localparam logic [PULSE_W-1:0] PULSE_RST      = 8'd5;
   localparam logic [TPS_W-1:0]   TPS_RST        = 24'd1000000;

   localparam logic [RATE_W-1:0] MIN_RAMP = 16'd10;
   localparam logic [LOW_W-1:0]  LOW_MAX  = {LOW_W{1'b1}};

   typedef struct packed {
      logic open_request;
      logic close_request;
      logic open_limit_one;
      logic closed_limit_one;
      logic open_limit_two;
      logic closed_limit_two;
   } req_type;

   typedef struct packed {
      logic step_one;
      logic step_two;
      logic direction;
      logic enable_n;
      logic moving;
   } rsp_type;

   typedef struct packed {
      logic [RATE_W-1:0]  start_rate;
      logic [RATE_W-1:0]  max_rate;
      logic [RATE_W-1:0]  ramp_steps;
      logic [COUNT_W-1:0] total_steps;
      logic [PULSE_W-1:0] pulse_ticks;
      logic [TPS_W-1:0]   ticks_per_second;
   } cfg_type;

   function automatic logic [PULSE_W-1:0] pulse_width(input logic [PULSE_W-1:0] p);
      return (p == '0) ? PULSE_W'(1) : p;
   endfunction

   function automatic logic [RATE_W-1:0] eff_ramp(input logic [RATE_W-1:0] r);
      return (r < MIN_RAMP) ? MIN_RAMP : r;
   endfunction

endpackage

// File: design/dual_stepper_ramp_door_drive.sv
// Two-door stepper drive with a trapezoidal step-rate profile.
// req channel: one beat per timer tick, carrying the open/close buttons and the
// four limit switches. rsp channel: exactly one beat per req beat, in order, with
// both step levels, direction, active-low driver enable and the moving flag.
// csr port: APB-style, registers at byte offsets 0x00 start_rate, 0x04 max_rate,
// 0x08 ramp_steps, 0x0C total_steps, 0x10 pulse_ticks, 0x14 ticks_per_second.
// Write them only while no beat is in flight.
// A plain tick's beat is held in item_ff and its result is then registered in the
// output register. A tick that opens a stepping slot first runs the period
// calculation, a 16-step bit-serial multiply and a 40-step restoring divide,
// before its result is registered.
// Flow: one beat in flight at a time; a new req beat is taken only once the held
// beat has committed, and rsp_stall can hold the output register.
// The result sits in an output register; while rsp_stall is high it holds, and one
// further req beat may be taken and held, waiting for the register to drain.
// Reset: synchronous, restores the register defaults, stops any move and
// disables the drivers.
module dual_stepper_ramp_door_drive
   import dsrdd_pkg::*;
#(
   parameter int STEP_COUNT_BITS = STEP_COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CMP_W = (STEP_COUNT_BITS > COUNT_W) ? STEP_COUNT_BITS : COUNT_W;

   localparam logic [1:0] ACT_IDLE  = 2'd0;
   localparam logic [1:0] ACT_OPEN  = 2'd1;
   localparam logic [1:0] ACT_CLOSE = 2'd2;

   localparam logic [1:0] CT_IDLE = 2'd0;
   localparam logic [1:0] CT_MUL  = 2'd1;
   localparam logic [1:0] CT_DIV  = 2'd2;
   localparam logic [1:0] CT_DONE = 2'd3;

   cfg_type cfg;

   logic [1:0]                 ctl_state_ff, ctl_state_in;
   logic                       item_vld_ff;
   req_type                    item_ff;
   logic                       rsp_valid_ff;
   rsp_type                    rsp_data_ff, rsp_data_in;

   logic [1:0]                 action_ff, action_in;
   logic [STEP_COUNT_BITS-1:0] slot_ff, slot_in;
   logic [PULSE_W-1:0]         pulse_left_ff, pulse_left_in;
   logic [LOW_W-1:0]           low_left_ff, low_left_in;
   logic                       gate_one_ff, gate_one_in;
   logic                       gate_two_ff, gate_two_in;
   logic                       enable_ff, enable_in;
   logic                       dir_ff, dir_in;

   logic                       in_slot, move_end, run, new_slot, need_calc;
   logic                       g1_new, g2_new, out_free, commit, take;
   logic [1:0]                 act_a;
   logic [STEP_COUNT_BITS-1:0] slot_b;
   logic [CMP_W-1:0]           slot_ext, slot_b_ext, total_ext, ramp_ext, j_ext;
   logic [RATE_W-1:0]          ramp, pos;
   logic [PULSE_W-1:0]         pw;

   logic                       mul_start, mul_done, div_done;
   logic [NUM_W-1:0]           num;
   logic [DVD_W-1:0]           dvd;
   logic [LOW_W-1:0]           low_res;

   dsrdd_csr #(
      .STEP_COUNT_BITS(STEP_COUNT_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dsrdd_mul u_mul (
      .clock      (clock),
      .reset      (reset),
      .start      (mul_start),
      .start_rate (cfg.start_rate),
      .max_rate   (cfg.max_rate),
      .ramp       (ramp),
      .pos        (pos),
      .tps        (cfg.ticks_per_second),
      .done       (mul_done),
      .num        (num),
      .dvd        (dvd)
   );

   dsrdd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (mul_done),
      .dvd   (dvd),
      .dsr   (num),
      .pw    (pw),
      .done  (div_done),
      .low   (low_res)
   );

   assign pw        = pulse_width(cfg.pulse_ticks);
   assign ramp      = eff_ramp(cfg.ramp_steps);
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = item_vld_ff;
   assign take      = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // tick evaluation on the held beat
   always_comb begin
      in_slot   = (pulse_left_ff != '0) || (low_left_ff != '0);
      slot_ext  = CMP_W'(slot_ff);
      total_ext = CMP_W'(cfg.total_steps);
      move_end  = (action_ff != ACT_IDLE) && !in_slot && (slot_ext >= total_ext);
      act_a     = move_end ? ACT_IDLE : action_ff;

      action_in = act_a;
      slot_b    = slot_ff;
      dir_in    = dir_ff;
      enable_in = enable_ff;
      if (act_a == ACT_IDLE) begin
         if (item_ff.close_request) begin
            action_in = ACT_CLOSE;
            dir_in    = 1'b0;
            enable_in = 1'b0;
            slot_b    = '0;
         end else if (item_ff.open_request) begin
            action_in = ACT_OPEN;
            dir_in    = 1'b1;
            enable_in = 1'b0;
            slot_b    = '0;
         end else begin
            enable_in = 1'b1;
         end
      end

      slot_b_ext = CMP_W'(slot_b);
      run        = (action_in != ACT_IDLE) && (in_slot || (slot_b_ext < total_ext));
      new_slot   = run && !in_slot;
      g1_new = ((action_in == ACT_OPEN) && item_ff.open_request && !item_ff.open_limit_one) ||
               ((action_in == ACT_CLOSE) && item_ff.close_request &&
                !item_ff.closed_limit_one);
      g2_new = ((action_in == ACT_OPEN) && item_ff.open_request && !item_ff.open_limit_two) ||
               ((action_in == ACT_CLOSE) && item_ff.close_request &&
                !item_ff.closed_limit_two);
      need_calc = new_slot && (g1_new || g2_new);

      // position within the ramp: slot index while accelerating, slots left
      // while decelerating, ramp length on the plateau
      ramp_ext = CMP_W'(ramp);
      j_ext    = total_ext - slot_b_ext;
      if (slot_b_ext < ramp_ext) begin
         pos = slot_b_ext[RATE_W-1:0];
      end else if (({1'b0, slot_b_ext} + {1'b0, ramp_ext}) > {1'b0, total_ext}) begin
         pos = j_ext[RATE_W-1:0];
      end else begin
         pos = ramp;
      end

      gate_one_in   = move_end ? 1'b0 : gate_one_ff;
      gate_two_in   = move_end ? 1'b0 : gate_two_ff;
      pulse_left_in = pulse_left_ff;
      low_left_in   = low_left_ff;
      slot_in       = slot_b;
      rsp_data_in.step_one = 1'b0;
      rsp_data_in.step_two = 1'b0;
      if (new_slot) begin
         gate_one_in = g1_new;
         gate_two_in = g2_new;
         if (g1_new || g2_new) begin
            pulse_left_in = pw;
            low_left_in   = low_res;
         end else begin
            pulse_left_in = '0;
            low_left_in   = LOW_W'(1);
         end
      end
      if (run) begin
         if (pulse_left_in != '0) begin
            rsp_data_in.step_one = gate_one_in;
            rsp_data_in.step_two = gate_two_in;
            pulse_left_in        = pulse_left_in - 1'b1;
         end else if (low_left_in != '0) begin
            low_left_in = low_left_in - 1'b1;
         end
         if ((pulse_left_in == '0) && (low_left_in == '0)) begin
            slot_in = slot_b + 1'b1;
         end
      end
      rsp_data_in.direction = dir_in;
      rsp_data_in.enable_n  = enable_in;
      rsp_data_in.moving    = (action_in != ACT_IDLE);
   end

   always_comb begin
      ctl_state_in = ctl_state_ff;
      mul_start    = 1'b0;
      commit       = 1'b0;
      case (ctl_state_ff)
         CT_IDLE: begin
            if (item_vld_ff) begin
               if (need_calc) begin
                  mul_start    = 1'b1;
                  ctl_state_in = CT_MUL;
               end else begin
                  commit = out_free;
               end
            end
         end
         CT_MUL: begin
            if (mul_done) begin
               ctl_state_in = CT_DIV;
            end
         end
         CT_DIV: begin
            if (div_done) begin
               ctl_state_in = CT_DONE;
            end
         end
         CT_DONE: begin
            if (out_free) begin
               commit       = 1'b1;
               ctl_state_in = CT_IDLE;
            end
         end
         default: ctl_state_in = CT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_state_ff  <= CT_IDLE;
         item_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         action_ff     <= ACT_IDLE;
         slot_ff       <= '0;
         pulse_left_ff <= '0;
         low_left_ff   <= '0;
         gate_one_ff   <= 1'b0;
         gate_two_ff   <= 1'b0;
         enable_ff     <= 1'b1;
         dir_ff        <= 1'b0;
      end else begin
         ctl_state_ff <= ctl_state_in;
         if (take) begin
            item_vld_ff <= 1'b1;
         end else if (commit) begin
            item_vld_ff <= 1'b0;
         end
         if (commit) begin
            rsp_valid_ff  <= 1'b1;
            action_ff     <= action_in;
            slot_ff       <= slot_in;
            pulse_left_ff <= pulse_left_in;
            low_left_ff   <= low_left_in;
            gate_one_ff   <= gate_one_in;
            gate_two_ff   <= gate_two_in;
            enable_ff     <= enable_in;
            dir_ff        <= dir_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_data;
      end
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_calc_has_item: assert property (@(posedge clock) disable iff (reset)
      (ctl_state_ff != CT_IDLE) |-> item_vld_ff)
      else $error("period calculation running without a held beat");

   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (ctl_state_ff == CT_MUL))
      else $error("multiply finished outside its phase");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (ctl_state_ff == CT_DIV))
      else $error("divide finished outside its phase");

   a_step_enabled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.step_one || rsp_data_ff.step_two)) |->
      (rsp_data_ff.moving && !rsp_data_ff.enable_n))
      else $error("step pulse while drivers disabled or idle");

   a_commit_frees_item: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff && !item_vld_ff)
      else $error("committed beat not moved to the output register");

endmodule

// File: design/dsrdd_csr.sv
module dsrdd_csr
   import dsrdd_pkg::*;
#(
   parameter int STEP_COUNT_BITS = STEP_COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   localparam logic [COUNT_W-1:0] CNT_MASK = (STEP_COUNT_BITS >= COUNT_W) ?
      {COUNT_W{1'b1}} : COUNT_W'((64'd1 << STEP_COUNT_BITS) - 64'd1);

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_rate       <= START_RATE_RST;
         cfg_ff.max_rate         <= MAX_RATE_RST;
         cfg_ff.ramp_steps       <= RAMP_RST;
         cfg_ff.total_steps      <= TOTAL_RST;
         cfg_ff.pulse_ticks      <= PULSE_RST;
         cfg_ff.ticks_per_second <= TPS_RST;
      end else if (wr_en) begin
         case (reg_idx)
            REG_START_RATE: cfg_ff.start_rate <= csr_pwdata[RATE_W-1:0];
            REG_MAX_RATE:   cfg_ff.max_rate   <= csr_pwdata[RATE_W-1:0];
            REG_RAMP_STEPS: cfg_ff.ramp_steps <= csr_pwdata[RATE_W-1:0];
            REG_TOTAL:      cfg_ff.total_steps <= csr_pwdata[COUNT_W-1:0] & CNT_MASK;
            REG_PULSE:      cfg_ff.pulse_ticks <= csr_pwdata[PULSE_W-1:0];
            REG_TPS:        cfg_ff.ticks_per_second <= csr_pwdata[TPS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_START_RATE: csr_prdata = CSR_DATA_W'(cfg_ff.start_rate);
         REG_MAX_RATE:   csr_prdata = CSR_DATA_W'(cfg_ff.max_rate);
         REG_RAMP_STEPS: csr_prdata = CSR_DATA_W'(cfg_ff.ramp_steps);
         REG_TOTAL:      csr_prdata = CSR_DATA_W'(cfg_ff.total_steps);
         REG_PULSE:      csr_prdata = CSR_DATA_W'(cfg_ff.pulse_ticks);
         REG_TPS:        csr_prdata = CSR_DATA_W'(cfg_ff.ticks_per_second);
         default:        csr_prdata = '0;
      endcase
   end

endmodule

// File: design/dsrdd_mul.sv
module dsrdd_mul
   import dsrdd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RATE_W-1:0] start_rate,
   input  logic [RATE_W-1:0] max_rate,
   input  logic [RATE_W-1:0] ramp,
   input  logic [RATE_W-1:0] pos,
   input  logic [TPS_W-1:0]  tps,
   output logic              done,
   output logic [NUM_W-1:0]  num,
   output logic [DVD_W-1:0]  dvd
);

   // num = start_rate*(ramp-pos) + max_rate*pos, dvd = tps*ramp; msb first
   localparam int CNT_W = $clog2(RATE_W);

   logic              busy_ff, done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [RATE_W-1:0] a_ff, b_ff, c_ff;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;

   always_comb begin
      num_in = {num_ff[NUM_W-2:0], 1'b0}
             + (a_ff[RATE_W-1] ? NUM_W'(start_rate) : '0)
             + (b_ff[RATE_W-1] ? NUM_W'(max_rate) : '0);
      dvd_in = {dvd_ff[DVD_W-2:0], 1'b0} + (c_ff[RATE_W-1] ? DVD_W'(tps) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(RATE_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= ramp - pos;
         b_ff   <= pos;
         c_ff   <= ramp;
         num_ff <= '0;
         dvd_ff <= '0;
      end else if (busy_ff) begin
         a_ff   <= {a_ff[RATE_W-2:0], 1'b0};
         b_ff   <= {b_ff[RATE_W-2:0], 1'b0};
         c_ff   <= {c_ff[RATE_W-2:0], 1'b0};
         num_ff <= num_in;
         dvd_ff <= dvd_in;
      end
   end

   assign done = done_ff;
   assign num  = num_ff;
   assign dvd  = dvd_ff;

endmodule

// File: design/dsrdd_div.sv
module dsrdd_div
   import dsrdd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DVD_W-1:0]   dvd,
   input  logic [NUM_W-1:0]   dsr,
   input  logic [PULSE_W-1:0] pw,
   output logic               done,
   output logic [LOW_W-1:0]   low
);

   // restoring divide, one quotient bit per cycle; a zero divisor yields all ones
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic               busy_ff, done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [NUM_W-1:0]   rem_ff, rem_in;
   logic [DVD_W-1:0]   q_ff, q_in, diff;
   logic [NUM_W:0]     rem_sh, rem_sub;
   logic               ge;
   logic [LOW_W-1:0]   low_ff, low_in;

   always_comb begin
      rem_sh  = {rem_ff, q_ff[DVD_W-1]};
      rem_sub = rem_sh - {1'b0, dsr};
      ge      = rem_sh >= {1'b0, dsr};
      rem_in  = ge ? rem_sub[NUM_W-1:0] : rem_sh[NUM_W-1:0];
      q_in    = {q_ff[DVD_W-2:0], ge};
      diff    = q_ff - DVD_W'(pw);
      if (q_ff <= DVD_W'(pw)) begin
         low_in = '0;
      end else if (diff > DVD_W'(LOW_MAX)) begin
         low_in = LOW_MAX;
      end else begin
         low_in = diff[LOW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (cnt_ff == CNT_W'(DVD_W)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dvd;
         rem_ff <= '0;
      end else if (busy_ff) begin
         if (cnt_ff == CNT_W'(DVD_W)) begin
            low_ff <= low_in;
         end else begin
            q_ff   <= q_in;
            rem_ff <= rem_in;
         end
      end
   end

   assign done = done_ff;
   assign low  = low_ff;

endmodule
